>>> rtl/flpms_pkg.sv
// ----------------------------------------------------------------------------
// Free-list pool package
// Shared constants, request kinds and the result record of the free-list
// pool with mark and sweep.
// ----------------------------------------------------------------------------
package flpms_pkg;

  // Default number of pool entries.
  localparam int POOL_DEPTH_DEF = 256;

  // Field widths fixed by the interface.
  localparam int KIND_W  = 3;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  // Reset value of the pool size register.
  localparam logic [COUNT_W-1:0] POOL_SIZE_RST = 9'd256;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INIT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MARK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SWEEP = 3'd4;

  // One result record.
  typedef struct packed {
    logic               granted;
    logic [INDEX_W-1:0] alloc_index;
    logic [COUNT_W-1:0] reclaimed;
    logic               pool_empty;
  } flpms_result_t;

endpackage

>>> rtl/free_list_pool_with_mark_sweep.sv
// ----------------------------------------------------------------------------
// Free-list pool with mark and sweep
// A pool of entries kept as a singly linked free list with one head. Each
// entry's link, free flag and live mark share one word of a single RAM.
//
//   Channel   Signals                                   Direction
//   in        in_valid, in_ready, kind, entry_index     request in
//   out       out_valid, out_ready, granted,            result out
//             alloc_index, reclaimed, pool_empty
//   cfg       cfg_we, cfg_wdata (pool_size)             register write
//
// One request is worked on at a time. Alloc, free and mark read the RAM word
// and then write it back; an alloc on an empty pool, an out-of-range free or
// mark, a sweep with no active entries and an unknown kind finish in the
// accept cycle. Init writes n words, n being pool_size held to 1..POOL_DEPTH,
// and sweep reads and writes back active words: one RAM word per cycle.
// Results go to an output register, so a waiting result stalls only the
// next request's completion. Reset clears control state only; RAM words are
// never read before init has written them, so there is no clearing pass.
// ----------------------------------------------------------------------------
module free_list_pool_with_mark_sweep
  import flpms_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [INDEX_W-1:0] entry_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               granted,
  output logic [INDEX_W-1:0] alloc_index,
  output logic [COUNT_W-1:0] reclaimed,
  output logic               pool_empty,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  // Widths derived from the pool depth.
  localparam int AW = $clog2(POOL_DEPTH + 1);          // counts and links
  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int WW = AW + 2;                          // link, free, live
  localparam int XW = (AW > COUNT_W) ? AW : COUNT_W;   // compare width
  localparam logic [AW-1:0] END_MARK = AW'(POOL_DEPTH);

  // State codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  // Control registers.
  logic [2:0]          state, state_next;
  logic [AW-1:0]       head, head_next;
  logic [AW-1:0]       active, active_next;
  logic [AW-1:0]       cnt, cnt_next;
  logic [COUNT_W-1:0]  rclm, rclm_next;
  logic                swp_vld, swp_vld_next;
  logic [COUNT_W-1:0]  pool_size;

  // Payload registers.
  logic [IW-1:0]       swp_addr;
  logic [KIND_W-1:0]   op_kind;
  logic [IW-1:0]       op_idx;
  flpms_result_t       pend;
  flpms_result_t       out_res;

  // RAM port signals.
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [WW-1:0]       mem_wdata, mem_rdata;
  logic [AW-1:0]       rd_link, rd_link_clamp;
  logic                rd_on_free, rd_live;

  // Completion of the current request.
  logic                fin;
  flpms_result_t       fin_res;
  logic                out_free;

  // Decoded request fields.
  logic                accept;
  logic [XW-1:0]       idx_x, ps_x;
  logic [AW-1:0]       init_n;
  logic                idx_ok;
  logic [AW-1:0]       cnt_inc;
  logic [AW-1:0]       init_link;
  logic                head_is_end;

  flpms_ram #(
    .WIDTH (WW),
    .DEPTH (POOL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Fields of the word read back.
  assign rd_link       = mem_rdata[WW-1:2];
  assign rd_on_free    = mem_rdata[1];
  assign rd_live       = mem_rdata[0];
  assign rd_link_clamp = (rd_link > END_MARK) ? END_MARK : rd_link;

  // Request decode and range checks.
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign idx_x       = XW'(entry_index);
  assign idx_ok      = idx_x < XW'(active);
  assign ps_x        = XW'(pool_size);
  assign head_is_end = (head == END_MARK);
  assign cnt_inc     = cnt + AW'(1);
  assign init_link   = (cnt_inc < active) ? cnt_inc : END_MARK;

  always_comb begin
    if (ps_x == '0) begin
      init_n = AW'(1);
    end else if (ps_x > XW'(POOL_DEPTH)) begin
      init_n = END_MARK;
    end else begin
      init_n = ps_x[AW-1:0];
    end
  end

  // Sequencer: request dispatch, RAM accesses and completion.
  always_comb begin
    logic [XW-1:0] head_x;
    state_next   = state;
    head_next    = head;
    active_next  = active;
    cnt_next     = cnt;
    rclm_next    = rclm;
    swp_vld_next = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    fin          = 1'b0;
    head_x       = XW'(head);
    fin_res      = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (kind)
            KIND_INIT: begin
              active_next = init_n;
              cnt_next    = '0;
              state_next  = S_INIT;
            end
            KIND_ALLOC: begin
              if (head_is_end) begin
                fin = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = head[IW-1:0];
                state_next = S_ALLOC;
              end
            end
            KIND_FREE, KIND_MARK: begin
              if (idx_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = idx_x[IW-1:0];
                state_next = S_RMW;
              end else begin
                fin = 1'b1;
              end
            end
            KIND_SWEEP: begin
              if (active == '0) begin
                fin = 1'b1;
              end else begin
                cnt_next   = '0;
                rclm_next  = '0;
                state_next = S_SWEEP;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC: begin
        // Pop the head; the handed-out entry leaves the list unmarked.
        mem_we              = 1'b1;
        mem_waddr           = head[IW-1:0];
        mem_wdata           = {rd_link, 1'b0, 1'b0};
        head_next           = rd_link_clamp;
        fin                 = 1'b1;
        fin_res.granted     = 1'b1;
        fin_res.alloc_index = head_x[INDEX_W-1:0];
      end

      S_RMW: begin
        if (op_kind == KIND_FREE) begin
          // Push unless the entry is already on the list.
          if (!rd_on_free) begin
            mem_we    = 1'b1;
            mem_waddr = op_idx;
            mem_wdata = {head, 1'b1, rd_live};
            head_next = AW'(op_idx);
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = op_idx;
          mem_wdata = {rd_link, rd_on_free, 1'b1};
        end
        fin = 1'b1;
      end

      S_INIT: begin
        // Link entry cnt to its successor and put it on the list unmarked.
        mem_we    = 1'b1;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = {init_link, 1'b1, 1'b0};
        cnt_next  = cnt_inc;
        if (cnt_inc == active) begin
          head_next = '0;
          fin       = 1'b1;
        end
      end

      S_SWEEP: begin
        // Read stage: one entry per cycle in index order.
        if (cnt < active) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt[IW-1:0];
          cnt_next     = cnt_inc;
          swp_vld_next = 1'b1;
        end
        // Write stage: free entries count as marked; clear marks, push the rest.
        if (swp_vld) begin
          mem_we    = 1'b1;
          mem_waddr = swp_addr;
          if (rd_live || rd_on_free) begin
            mem_wdata = {rd_link, rd_on_free, 1'b0};
          end else begin
            mem_wdata = {head, 1'b1, 1'b0};
            head_next = AW'(swp_addr);
            if (rclm != '1) begin
              rclm_next = rclm + COUNT_W'(1);
            end
          end
          if (!(cnt < active)) begin
            fin               = 1'b1;
            fin_res.reclaimed = rclm_next;
          end
        end
      end

      S_WAIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    fin_res.pool_empty = (head_next == END_MARK);

    if (fin) begin
      state_next = out_free ? S_IDLE : S_WAIT;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= END_MARK;
      active    <= '0;
      cnt       <= '0;
      rclm      <= '0;
      swp_vld   <= 1'b0;
      pool_size <= POOL_SIZE_RST;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      active  <= active_next;
      cnt     <= cnt_next;
      rclm    <= rclm_next;
      swp_vld <= swp_vld_next;
      if (cfg_we) begin
        pool_size <= cfg_wdata;
      end
      if ((fin && out_free) || (state == S_WAIT && out_free)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: request operands, sweep address and results.
  always_ff @(posedge clk) begin
    swp_addr <= cnt[IW-1:0];
    if (accept) begin
      op_kind <= kind;
      op_idx  <= idx_x[IW-1:0];
    end
    if (fin) begin
      pend <= fin_res;
    end
    if (fin && out_free) begin
      out_res <= fin_res;
    end else if (state == S_WAIT && out_free) begin
      out_res <= pend;
    end
  end

  assign granted     = out_res.granted;
  assign alloc_index = out_res.alloc_index;
  assign reclaimed   = out_res.reclaimed;
  assign pool_empty  = out_res.pool_empty;

endmodule

>>> rtl/flpms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module flpms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
